FILE: hw/rtl/orl_pkg.sv
// Shared types, codes and constants of the observed rank locator.
`timescale 1ns / 1ps
package orl_pkg;

  // Field widths of the request and result items
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned SCEN_W  = 3;
  localparam int unsigned STAT_W  = 6;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SHARE_W = 17;
  localparam int unsigned LEVEL_W = 2;

  // Ratio operands: numerator 2b+e, denominator 2(b+a+e), complement 2a+e
  localparam int unsigned NUM_W  = CNT_W + 2;
  localparam int unsigned DEN_W  = CNT_W + 3;
  localparam int unsigned MULT_W = 10;
  localparam int unsigned STAR_STEPS = 6;

  // Stream packing
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned SCEN_LSB   = 0;
  localparam int unsigned STAT_LSB   = SCEN_LSB + SCEN_W;
  localparam int unsigned VAL_LSB    = STAT_LSB + STAT_W;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - (SHARE_W + LEVEL_W + CNT_W);
  localparam int unsigned LEVEL_LSB  = SHARE_W;

  // Register port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam logic [1:0] REG_TOLERANCE    = 2'd0;
  localparam logic [1:0] REG_FILTER_EN    = 2'd1;
  localparam logic [1:0] REG_FILTER_LIMIT = 2'd2;

  localparam logic [TOL_W-1:0]        TOL_RESET   = 16'd66;
  localparam logic signed [VAL_W-1:0] LIMIT_RESET = 32'sd65536;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_ELEM  = 2'd1,
    MODE_QUERY = 2'd2
  } orl_mode_e;

  localparam logic [LEVEL_W-1:0] LEVEL_0 = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_1 = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_2 = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_3 = 2'd3;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] rest;
    logic [DEN_W-1:0] den;
  } orl_div_req_t;

  typedef struct packed {
    logic               done;
    logic [SHARE_W-1:0] share;
    logic [LEVEL_W-1:0] level;
  } orl_div_res_t;

  // Even steps test d > K*(2a+e) (high tail), odd steps d > K*(2b+e) (low tail)
  function automatic logic [MULT_W-1:0] star_mult(input logic [2:0] step);
    logic [MULT_W-1:0] k;
    unique case (step)
      3'd0, 3'd1: k = 10'd1000;
      3'd2, 3'd3: k = 10'd100;
      3'd4, 3'd5: k = 10'd20;
      default:    k = '0;
    endcase
    return k;
  endfunction

endpackage

FILE: hw/rtl/observed_rank_locator_unit.sv
// Top level of the observed rank locator: request decode, counter update and query path.
//
// Requests arrive on the s_axis channel; tuser selects load observed value (0), simulated
// element (1) or query (2). Loads, ignored requests and elements of a skipped record leave
// the block ready for the next request. For a counted element the counter memory and the
// observed table are read at acceptance and the bumped counter is written back in the
// following cycle, so no two accesses to one entry overlap. A query reads the cell, forms
// the ratio operands in the next cycle and runs the bit-serial divider; its result enters
// the m_axis output register once the divider is done and the register is free, and only
// then is the next request taken. Modes 0, 1 and 3 give no result. Results are held in an
// output register: while the receiver stalls, loads and elements still go on, and a
// further query waits in the divider, with s_axis_tready low, until the register frees up.
// After reset the block sweeps the counter memory and the observed table to zero, one
// entry per cycle, over all NUM_SCENARIOS*NUM_STATS cells (512 by default); s_axis_tready
// stays low during the sweep. Register writes on the APB port are taken at any time,
// and must only be issued while no request is in progress.
`timescale 1ns / 1ps
module observed_rank_locator_unit #(
  parameter int unsigned NUM_SCENARIOS = 8,
  parameter int unsigned NUM_STATS     = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [orl_pkg::PADDR_W-1:0]       paddr,
  input  logic [orl_pkg::PDATA_W-1:0]       pwdata,
  output logic [orl_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [2:0] scenario, [8:3] stat_index, [40:9] sample_value, [47:41] zero
  input  logic [orl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] mode
  input  logic [orl_pkg::MODE_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [16:0] share_below, [18:17] star_level, [50:19] accepted_records, [55:51] zero
  output logic [orl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [0] empty_cell
  output logic [0:0]                        m_axis_tuser
);
  import orl_pkg::*;

  localparam int unsigned CELLS     = NUM_SCENARIOS * NUM_STATS;
  localparam int unsigned CELL_AW   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned OBS_AW    = (NUM_STATS > 1) ? $clog2(NUM_STATS) : 1;
  localparam int unsigned CNT_RAM_W = 3 * CNT_W;

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_UPDATE, ST_QPREP, ST_QRUN} state_e;

  // configuration
  logic [TOL_W-1:0]        tol_q;
  logic                    flt_en_q;
  logic signed [VAL_W-1:0] flt_lim_q;
  logic                    cfg_we;
  logic [1:0]              cfg_idx;

  // request fields
  orl_mode_e               in_mode;
  logic [SCEN_W-1:0]       in_scen;
  logic [STAT_W-1:0]       in_stat;
  logic signed [VAL_W-1:0] in_val;
  logic                    scen_ok, stat_ok, accept;
  logic [CELL_AW-1:0]      in_cell;

  // record state
  logic                    skip_q, skip_d;
  logic [CNT_W-1:0]        total_q, total_d;
  logic                    rec_start, rec_drop, count_go;

  // per-request hold
  state_e                  state_q;
  logic [CELL_AW-1:0]      clr_q;
  logic                    clr_last;
  logic [CELL_AW-1:0]      cell_q;
  logic signed [VAL_W-1:0] val_q;
  logic                    cell_ok_q;
  logic [CNT_W-1:0]        snap_q;

  // memories
  logic                    cnt_we, obs_we;
  logic [CELL_AW-1:0]      cnt_waddr;
  logic [CNT_RAM_W-1:0]    cnt_wdata, cnt_rdata;
  logic [OBS_AW-1:0]       obs_waddr;
  logic [VAL_W-1:0]        obs_wdata, obs_rdata;

  // counter update
  logic [CNT_W-1:0]        below_c, above_c, equal_c;
  logic signed [VAL_W:0]   diff, tol_ext;
  logic                    go_below, go_above;
  logic [CNT_W-1:0]        below_n, above_n, equal_n;

  // query path
  orl_div_req_t            div_req;
  orl_div_res_t            div_res;
  logic                    out_load;
  logic                    m_valid_q;
  logic                    empty_q, empty_o_q;
  logic [SHARE_W-1:0]      share_q;
  logic [LEVEL_W-1:0]      level_q;
  logic [CNT_W-1:0]        acc_q;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      REG_TOLERANCE:    prdata = PDATA_W'(tol_q);
      REG_FILTER_EN:    prdata = PDATA_W'(flt_en_q);
      REG_FILTER_LIMIT: prdata = flt_lim_q;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q     <= TOL_RESET;
      flt_en_q  <= 1'b0;
      flt_lim_q <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TOLERANCE:    tol_q     <= pwdata[TOL_W-1:0];
        REG_FILTER_EN:    flt_en_q  <= pwdata[0];
        REG_FILTER_LIMIT: flt_lim_q <= pwdata;
        default:          ;
      endcase
    end
  end

  // ---------------- request decode ----------------
  assign in_mode  = orl_mode_e'(s_axis_tuser);
  assign in_scen  = s_axis_tdata[SCEN_LSB +: SCEN_W];
  assign in_stat  = s_axis_tdata[STAT_LSB +: STAT_W];
  assign in_val   = s_axis_tdata[VAL_LSB +: VAL_W];
  assign scen_ok  = 32'(in_scen) < NUM_SCENARIOS;
  assign stat_ok  = 32'(in_stat) < NUM_STATS;
  assign in_cell  = CELL_AW'(32'(in_scen) * NUM_STATS + 32'(in_stat));
  assign s_axis_tready = state_q == ST_IDLE;
  assign accept   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    rec_start = accept && (in_mode == MODE_ELEM) && (in_stat == '0);
    rec_drop  = !scen_ok || (flt_en_q && (in_val > flt_lim_q));
    skip_d    = rec_start ? rec_drop : skip_q;
    total_d   = total_q;
    if (rec_start && !rec_drop && (total_q != '1)) begin
      total_d = total_q + CNT_W'(1);
    end
    count_go  = accept && (in_mode == MODE_ELEM) && !skip_d && scen_ok && stat_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q  <= 1'b0;
      total_q <= '0;
    end else begin
      skip_q  <= skip_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cell_q    <= in_cell;
      val_q     <= in_val;
      cell_ok_q <= scen_ok && stat_ok;
      snap_q    <= total_q;
    end
  end

  // ---------------- counter update ----------------
  assign below_c = cnt_rdata[0 +: CNT_W];
  assign above_c = cnt_rdata[CNT_W +: CNT_W];
  assign equal_c = cnt_rdata[2*CNT_W +: CNT_W];

  always_comb begin
    diff     = $signed({obs_rdata[VAL_W-1], obs_rdata}) - $signed({val_q[VAL_W-1], val_q});
    tol_ext  = $signed({{(VAL_W + 1 - TOL_W){1'b0}}, tol_q});
    go_below = diff > tol_ext;
    go_above = !go_below && (diff < -tol_ext);
    below_n  = below_c;
    above_n  = above_c;
    equal_n  = equal_c;
    priority if (go_below) begin
      if (below_c != '1) below_n = below_c + CNT_W'(1);
    end else if (go_above) begin
      if (above_c != '1) above_n = above_c + CNT_W'(1);
    end else begin
      if (equal_c != '1) equal_n = equal_c + CNT_W'(1);
    end
  end

  assign clr_last  = clr_q == CELL_AW'(CELLS - 1);
  assign cnt_we    = (state_q == ST_CLEAR) || (state_q == ST_UPDATE);
  assign cnt_waddr = (state_q == ST_CLEAR) ? clr_q : cell_q;
  assign cnt_wdata = (state_q == ST_CLEAR) ? '0 : {equal_n, above_n, below_n};

  assign obs_we    = ((state_q == ST_CLEAR) && (32'(clr_q) < NUM_STATS)) ||
                     (accept && (in_mode == MODE_LOAD) && stat_ok);
  assign obs_waddr = (state_q == ST_CLEAR) ? OBS_AW'(clr_q) : OBS_AW'(in_stat);
  assign obs_wdata = (state_q == ST_CLEAR) ? '0 : in_val;

  orl_ram #(
    .WIDTH (CNT_RAM_W),
    .DEPTH (CELLS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (in_cell),
    .rdata_o (cnt_rdata)
  );

  orl_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NUM_STATS)
  ) u_obs_ram (
    .clk_i   (clk_i),
    .we_i    (obs_we),
    .waddr_i (obs_waddr),
    .wdata_i (obs_wdata),
    .raddr_i (OBS_AW'(in_stat)),
    .rdata_o (obs_rdata)
  );

  // ---------------- query path ----------------
  always_comb begin
    div_req.start = state_q == ST_QPREP;
    div_req.num   = {1'b0, below_c, 1'b0} + NUM_W'(equal_c);
    div_req.rest  = {1'b0, above_c, 1'b0} + NUM_W'(equal_c);
    // 2(b+a+e) as (2b+e) + (2a+e)
    div_req.den   = {1'b0, div_req.num} + {1'b0, div_req.rest};
  end

  orl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .ack_i  (out_load),
    .res_o  (div_res)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == ST_QPREP) begin
      empty_q <= !cell_ok_q || (div_req.den == '0);
    end
  end

  assign out_load = (state_q == ST_QRUN) && div_res.done && (!m_valid_q || m_axis_tready);

  // ---------------- control ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
      share_q   <= '0;
      level_q   <= LEVEL_0;
      empty_o_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      m_valid_q <= out_load || (m_valid_q && !m_axis_tready);
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + CELL_AW'(1);
          if (clr_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (count_go) begin
            state_q <= ST_UPDATE;
          end else if (accept && (in_mode == MODE_QUERY)) begin
            state_q <= ST_QPREP;
          end
        end
        ST_UPDATE: state_q <= ST_IDLE;
        ST_QPREP:  state_q <= ST_QRUN;
        ST_QRUN: begin
          if (out_load) begin
            share_q   <= empty_q ? '0 : div_res.share;
            level_q   <= empty_q ? LEVEL_3 : div_res.level;
            empty_o_q <= empty_q;
            acc_q     <= snap_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, acc_q, level_q, share_q};
  assign m_axis_tuser  = empty_o_q;

endmodule

FILE: hw/rtl/orl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module orl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/orl_div.sv
// Bit-serial ratio unit: truncated Q1.16 share and star level of one cell.
`timescale 1ns / 1ps
module orl_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  orl_pkg::orl_div_req_t req_i,
  input  logic                  ack_i,
  output orl_pkg::orl_div_res_t res_o
);
  import orl_pkg::*;

  typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_DONE} dv_state_e;

  localparam int unsigned STEP_W = $clog2(SHARE_W);
  localparam int unsigned PROD_W = NUM_W + MULT_W;

  dv_state_e             state_q;
  logic [STEP_W-1:0]     step_q;
  logic [DEN_W-1:0]      rem_q, den_q;
  logic [NUM_W-1:0]      num_q, rest_q;
  logic [SHARE_W-1:0]    quo_q;
  logic [STAR_STEPS-1:0] flags_q;

  logic [DEN_W:0]        trial;
  logic                  fits;
  logic [DEN_W-1:0]      rem_d;
  logic [NUM_W-1:0]      star_x;
  logic [PROD_W-1:0]     star_prod;
  logic                  star_hit;
  logic                  last_step;
  logic [LEVEL_W-1:0]    level;

  always_comb begin
    // first step takes the integer bit, later steps shift in a zero
    trial     = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    fits      = trial >= {1'b0, den_q};
    rem_d     = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    star_x    = step_q[0] ? num_q : rest_q;
    star_prod = PROD_W'(star_x) * PROD_W'(star_mult(step_q[2:0]));
    star_hit  = PROD_W'(den_q) > star_prod;
    last_step = step_q == STEP_W'(SHARE_W - 1);
  end

  always_comb begin
    priority if (flags_q[0] || flags_q[1]) begin
      level = LEVEL_3;
    end else if (flags_q[2] || flags_q[3]) begin
      level = LEVEL_2;
    end else if (flags_q[4] || flags_q[5]) begin
      level = LEVEL_1;
    end else begin
      level = LEVEL_0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        DV_IDLE: begin
          if (req_i.start) begin
            state_q <= DV_RUN;
            step_q  <= '0;
          end
        end
        DV_RUN: begin
          step_q <= step_q + STEP_W'(1);
          if (last_step) begin
            state_q <= DV_DONE;
          end
        end
        DV_DONE: begin
          if (ack_i) begin
            state_q <= DV_IDLE;
          end
        end
        default: state_q <= DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DV_IDLE && req_i.start) begin
      rem_q   <= {1'b0, req_i.num};
      den_q   <= req_i.den;
      num_q   <= req_i.num;
      rest_q  <= req_i.rest;
      quo_q   <= '0;
      flags_q <= '0;
    end else if (state_q == DV_RUN) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[SHARE_W-2:0], fits};
      if (32'(step_q) < STAR_STEPS) begin
        flags_q[step_q[2:0]] <= star_hit;
      end
    end
  end

  assign res_o.done  = state_q == DV_DONE;
  assign res_o.share = quo_q;
  assign res_o.level = level;

endmodule

FILE: hw/rtl/orl_checker.sv
// Port-level assertions for the observed rank locator, bound to the top level.
`timescale 1ns / 1ps
module orl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [orl_pkg::MODE_W-1:0]     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [orl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                     m_axis_tuser
);
  import orl_pkg::*;

  logic [SHARE_W-1:0] share;
  logic [LEVEL_W-1:0] level;

  assign share = m_axis_tdata[SHARE_W-1:0];
  assign level = m_axis_tdata[LEVEL_LSB +: LEVEL_W];

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_empty_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (share == '0) && (level == LEVEL_3))
    else $error("empty cell result not coded as zero share, level 3");

  a_share_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> share <= SHARE_W'(65536))
    else $error("share above one");

  // a share at either end lies in the outermost tail
  a_tail_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((share == '0) || (share == SHARE_W'(65536))) |-> level == LEVEL_3)
    else $error("extreme share without top star level");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_QUERY) |=> !s_axis_tready)
    else $error("request taken while a query is in progress");

endmodule

bind observed_rank_locator_unit orl_checker u_orl_checker (.*);

FILE: tb/tb_observed_rank_locator_unit.sv
// Self-checking testbench for the observed rank locator: directed rows, then random records.
`timescale 1ns / 1ps
module tb_observed_rank_locator_unit;
  import orl_pkg::*;

  localparam int unsigned NUM_SCEN_TB   = 8;
  localparam int unsigned NUM_STAT_TB   = 64;
  localparam int unsigned CELLS_TB      = NUM_SCEN_TB * NUM_STAT_TB;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [CNT_W-1:0]  CNT_MAX     = '1;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASE_ITEMS   = 125;
  localparam int unsigned NUM_PHASES    = 5;
  localparam int unsigned DIR_ROWS      = 23;

  typedef struct packed {
    logic [SHARE_W-1:0] share;
    logic [LEVEL_W-1:0] level;
    logic               empty;
    logic [CNT_W-1:0]   records;
  } rank_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SCEN_W-1:0] scen;
    logic [STAT_W-1:0] stat;
    logic [VAL_W-1:0]  val;
    logic              typed;
    rank_t             want;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  // Predictor state and register copies
  logic signed [VAL_W-1:0] observed_val [NUM_STAT_TB];
  logic [CNT_W-1:0]        below_cnt [CELLS_TB];
  logic [CNT_W-1:0]        above_cnt [CELLS_TB];
  logic [CNT_W-1:0]        equal_cnt [CELLS_TB];
  logic                    skip_record = 1'b0;
  logic [CNT_W-1:0]        record_count = '0;
  logic [TOL_W-1:0]        tol_cfg = TOL_RESET;
  logic                    filt_en_cfg = 1'b0;
  logic signed [VAL_W-1:0] filt_lim_cfg = LIMIT_RESET;

  rank_t       pending_ranks [$];
  int unsigned failures = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  bit          hold_want = 1'b0;
  dir_row_t    dir_rows [DIR_ROWS];

  observed_rank_locator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

  // Advance the predictor by one accepted request; a query yields its rank result.
  task automatic apply_request(input logic [MODE_W-1:0] mode, input logic [SCEN_W-1:0] scen,
                               input logic [STAT_W-1:0] stat, input logic [VAL_W-1:0] val,
                               output bit has_rank, output rank_t rank);
    int unsigned       slot;
    longint            diff;
    longint            tol_l;
    longint unsigned   b, e, tot, n, d;
    has_rank = 1'b0;
    rank = '0;
    slot = 32'({scen, stat});
    case (mode)
      MODE_LOAD: observed_val[stat] = val;
      MODE_ELEM: begin
        if (stat == '0) begin
          if (filt_en_cfg && ($signed(val) > filt_lim_cfg)) begin
            skip_record = 1'b1;
          end else begin
            skip_record = 1'b0;
            record_count = sat_inc(record_count);
          end
        end
        if (!skip_record) begin
          diff  = longint'(observed_val[stat]) - longint'($signed(val));
          tol_l = longint'(tol_cfg);
          if (diff > tol_l) below_cnt[slot] = sat_inc(below_cnt[slot]);
          else if (diff < -tol_l) above_cnt[slot] = sat_inc(above_cnt[slot]);
          else equal_cnt[slot] = sat_inc(equal_cnt[slot]);
        end
      end
      MODE_QUERY: begin
        has_rank = 1'b1;
        rank.records = record_count;
        b   = 64'(below_cnt[slot]);
        e   = 64'(equal_cnt[slot]);
        tot = b + 64'(above_cnt[slot]) + e;
        if (tot == 0) begin
          rank.share = '0;
          rank.level = LEVEL_3;
          rank.empty = 1'b1;
        end else begin
          n = 2 * b + e;
          d = 2 * tot;
          rank.empty = 1'b0;
          rank.share = SHARE_W'((n << 16) / d);
          // compare the exact ratio against the tail bounds
          if (1000 * n > 999 * d || 1000 * n < d) rank.level = LEVEL_3;
          else if (100 * n > 99 * d || 100 * n < d) rank.level = LEVEL_2;
          else if (100 * n > 95 * d || 100 * n < 5 * d) rank.level = LEVEL_1;
          else rank.level = LEVEL_0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SCEN_W-1:0] scen,
                           input logic [STAT_W-1:0] stat, input logic [VAL_W-1:0] val,
                           input bit typed, input rank_t typed_rank);
    bit    has_rank;
    rank_t rank;
    while (!tx_steady && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({val, stat, scen});
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_request(mode, scen, stat, val, has_rank, rank);
    if (has_rank) pending_ranks.push_back(typed ? typed_rank : rank);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TOLERANCE:    tol_cfg = data[TOL_W-1:0];
      REG_FILTER_EN:    filt_en_cfg = data[0];
      REG_FILTER_LIMIT: filt_lim_cfg = data;
      default: ;
    endcase
  endtask

  // Wait for every outstanding query, then let trailing element updates retire.
  task automatic drain_results();
    while (pending_ranks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Value near the stored observation, hitting the band edges often.
  function automatic logic [VAL_W-1:0] near_value(input logic [STAT_W-1:0] stat);
    int off;
    int span;
    span = int'(tol_cfg) + 1;
    case ($urandom_range(3))
      0:       off = int'(tol_cfg);
      1:       off = span;
      default: off = int'($urandom_range(2 * span + 2));
    endcase
    if ($urandom_range(1) == 1) off = -off;
    return observed_val[stat] + off;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_want) begin
        hold_want = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= rx_steady || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk_i) begin : rank_check
    rank_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_ranks.size() == 0) begin
        $error("result with nothing pending: share_below %0d", m_axis_tdata[SHARE_W-1:0]);
        failures++;
      end else begin
        want = pending_ranks.pop_front();
        if (m_axis_tdata[SHARE_W-1:0] !== want.share) begin
          $error("share_below: expected %0d, got %0d", want.share, m_axis_tdata[SHARE_W-1:0]);
          failures++;
        end
        if (m_axis_tdata[LEVEL_LSB +: LEVEL_W] !== want.level) begin
          $error("star_level: expected %0d, got %0d", want.level,
                 m_axis_tdata[LEVEL_LSB +: LEVEL_W]);
          failures++;
        end
        if (m_axis_tuser[0] !== want.empty) begin
          $error("empty_cell: expected %0d, got %0d", want.empty, m_axis_tuser[0]);
          failures++;
        end
        if (m_axis_tdata[LEVEL_LSB + LEVEL_W +: CNT_W] !== want.records) begin
          $error("accepted_records: expected %0d, got %0d", want.records,
                 m_axis_tdata[LEVEL_LSB + LEVEL_W +: CNT_W]);
          failures++;
        end
      end
    end
  end

  initial begin
    int unsigned       len, pick;
    logic [SCEN_W-1:0] scen;
    logic [STAT_W-1:0] stat;
    logic [VAL_W-1:0]  v;
    logic [TOL_W-1:0]  tol_w;
    logic              en_w;
    logic [VAL_W-1:0]  lim_w;

    for (int i = 0; i < NUM_STAT_TB; i++) observed_val[i] = '0;
    for (int i = 0; i < CELLS_TB; i++) begin
      below_cnt[i] = '0;
      above_cnt[i] = '0;
      equal_cnt[i] = '0;
    end

    // mode, scenario, stat, value, typed, {share, level, empty, records}
    dir_rows[0]  = '{MODE_QUERY,  3'd0, 6'd0,  32'h0,        1'b1, '{17'd0,     LEVEL_3, 1'b1, 32'd0}};
    dir_rows[1]  = '{MODE_QUERY,  3'd7, 6'd63, 32'h0,        1'b1, '{17'd0,     LEVEL_3, 1'b1, 32'd0}};
    // element ahead of any record start still counts
    dir_rows[2]  = '{MODE_ELEM,   3'd0, 6'd5,  32'h0,        1'b0, '0};
    dir_rows[3]  = '{MODE_QUERY,  3'd0, 6'd5,  32'h0,        1'b1, '{17'd32768, LEVEL_0, 1'b0, 32'd0}};
    dir_rows[4]  = '{MODE_LOAD,   3'd0, 6'd0,  32'h7FFFFFFF, 1'b0, '0};
    dir_rows[5]  = '{MODE_LOAD,   3'd0, 6'd63, 32'h80000000, 1'b0, '0};
    dir_rows[6]  = '{MODE_ELEM,   3'd0, 6'd0,  32'h80000000, 1'b0, '0};
    dir_rows[7]  = '{MODE_ELEM,   3'd0, 6'd63, 32'h7FFFFFFF, 1'b0, '0};
    dir_rows[8]  = '{MODE_QUERY,  3'd0, 6'd0,  32'h0,        1'b1, '{17'd65536, LEVEL_3, 1'b0, 32'd1}};
    dir_rows[9]  = '{MODE_QUERY,  3'd0, 6'd63, 32'h0,        1'b1, '{17'd0,     LEVEL_3, 1'b0, 32'd1}};
    dir_rows[10] = '{MODE_UNUSED, 3'd7, 6'd63, 32'hFFFFFFFF, 1'b0, '0};
    dir_rows[11] = '{MODE_LOAD,   3'd0, 6'd1,  32'd100,      1'b0, '0};
    dir_rows[12] = '{MODE_ELEM,   3'd7, 6'd0,  32'h0,        1'b0, '0};
    // band edges around 100 with the reset tolerance
    dir_rows[13] = '{MODE_ELEM,   3'd7, 6'd1,  32'd166,      1'b0, '0};
    dir_rows[14] = '{MODE_ELEM,   3'd7, 6'd1,  32'd167,      1'b0, '0};
    dir_rows[15] = '{MODE_ELEM,   3'd7, 6'd1,  32'd34,       1'b0, '0};
    dir_rows[16] = '{MODE_ELEM,   3'd7, 6'd1,  32'd33,       1'b0, '0};
    dir_rows[17] = '{MODE_QUERY,  3'd7, 6'd1,  32'h0,        1'b1, '{17'd32768, LEVEL_0, 1'b0, 32'd2}};
    dir_rows[18] = '{MODE_ELEM,   3'd5, 6'd1,  32'h0,        1'b0, '0};
    dir_rows[19] = '{MODE_QUERY,  3'd5, 6'd1,  32'h0,        1'b1, '{17'd65536, LEVEL_3, 1'b0, 32'd2}};
    dir_rows[20] = '{MODE_QUERY,  3'd7, 6'd0,  32'h0,        1'b0, '0};
    dir_rows[21] = '{MODE_ELEM,   3'd2, 6'd42, 32'h12345678, 1'b0, '0};
    dir_rows[22] = '{MODE_QUERY,  3'd2, 6'd42, 32'h0,        1'b0, '0};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_rows[i].mode, dir_rows[i].scen, dir_rows[i].stat, dir_rows[i].val,
                dir_rows[i].typed, dir_rows[i].want);
    end
    s_axis_tvalid <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin tol_w = TOL_RESET; en_w = 1'b0; lim_w = LIMIT_RESET; end
        1: begin tol_w = '0; en_w = 1'b1; lim_w = '0; end
        2: begin tol_w = '1; en_w = 1'b1; lim_w = 32'h80000000; end
        3: begin tol_w = TOL_W'($urandom_range(2000)); en_w = 1'b1; lim_w = 32'h7FFFFFFF; end
        default: begin tol_w = TOL_W'($urandom()); en_w = 1'b1; lim_w = $urandom(); end
      endcase
      reg_write(REG_TOLERANCE, PDATA_W'(tol_w));
      reg_write(REG_FILTER_EN, PDATA_W'(en_w));
      reg_write(REG_FILTER_LIMIT, lim_w);
      tx_steady = (ph == 1);
      rx_steady = (ph == 1);
      if (ph == 3) hold_want = 1'b1;
      items_sent = 0;

      while (items_sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // well-formed record: start element, then a few statistics
          scen = SCEN_W'($urandom_range(7));
          len  = $urandom_range(6, 1);
          case ($urandom_range(4))
            0:       v = filt_lim_cfg;
            1:       v = filt_lim_cfg + 1;
            2:       v = filt_lim_cfg - 1;
            3:       v = $urandom();
            default: v = near_value('0);
          endcase
          send_item(MODE_ELEM, scen, '0, v, 1'b0, '0);
          for (int k = 1; k < len; k++) begin
            stat = STAT_W'(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(7, 1));
            send_item(MODE_ELEM, scen, stat, near_value(stat), 1'b0, '0);
          end
          if ($urandom_range(2) == 0)
            send_item(MODE_QUERY, SCEN_W'($urandom_range(7)), STAT_W'($urandom_range(7)),
                      $urandom(), 1'b0, '0);
        end else if (pick < 80) begin
          stat = STAT_W'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7));
          v = ($urandom_range(1) == 0) ? $urandom() : near_value(stat);
          send_item(MODE_LOAD, SCEN_W'($urandom_range(7)), stat, v, 1'b0, '0);
        end else if (pick < 90) begin
          send_item(MODE_QUERY, SCEN_W'($urandom_range(7)), STAT_W'($urandom_range(63)),
                    $urandom(), 1'b0, '0);
        end else if (pick < 95) begin
          send_item(MODE_UNUSED, SCEN_W'($urandom_range(7)), STAT_W'($urandom_range(63)),
                    $urandom(), 1'b0, '0);
        end else begin
          send_item(MODE_ELEM, SCEN_W'($urandom_range(7)), STAT_W'($urandom_range(63)),
                    $urandom(), 1'b0, '0);
        end
      end
      s_axis_tvalid <= 1'b0;
    end

    drain_results();
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
